>>> hw/rtl/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define MSPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MSPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MSPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MSPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/mspt_pkg.sv
// types and constants of the stepper position tracker
package mspt_pkg;

	localparam int OPW  = 24;
	localparam int CNTW = $clog2(OPW);

	localparam logic [15:0] RST_STEPS_PER_TURN = 16'd2000;
	localparam logic [15:0] RST_SLOT_STEPS     = 16'd250;
	localparam logic [15:0] RST_CHUNK_STEPS    = 16'd10;
	localparam logic [7:0]  RST_CW_OVERSHOOT   = 8'd10;

	localparam logic [1:0] CFG_STEPS_PER_TURN = 2'd0;
	localparam logic [1:0] CFG_SLOT_STEPS     = 2'd1;
	localparam logic [1:0] CFG_CHUNK_STEPS    = 2'd2;
	localparam logic [1:0] CFG_CW_OVERSHOOT   = 2'd3;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_CCW  = 2'd1,
		OP_CW   = 2'd2,
		OP_HOME = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_RUN,
		ST_PUSH
	} state_t;

	typedef enum logic [3:0] {
		U_GOAL,
		U_PLATE,
		U_DIST,
		U_ADV,
		U_CCW,
		U_SLOT,
		U_NEWP,
		U_NEWG,
		U_NEWO,
		U_OFF,
		U_BACK,
		U_FWD
	} uop_t;

	typedef struct packed {
		logic [15:0] steps_per_turn;
		logic [15:0] slot_steps;
		logic [15:0] chunk_steps;
		logic [7:0]  cw_overshoot;
	} cfg_t;

	typedef struct packed {
		logic        last;
		logic        arrived;
		logic        ready_res;
		logic        release_after;
		logic        step_forward;
		logic [15:0] step_count;
	} res_t;

	typedef struct packed {
		logic valid;
		logic two;
		res_t r0;
		res_t r1;
	} push_t;

endpackage

>>> hw/rtl/mspt_mod.sv
// bit serial remainder unit, one quotient bit per cycle
module mspt_mod
	import mspt_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [OPW-1:0]  x,
	input  logic [16:0]     turn,
	output logic            done,
	output logic [15:0]     rem
);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [OPW-1:0]  x_q;
	logic [15:0]     rem_q;
	logic [16:0]     trial;
	logic [16:0]     diff;
	logic [15:0]     rem_nx;

	assign trial  = {rem_q, x_q[OPW-1]};
	assign diff   = trial - turn;
	assign rem_nx = (trial >= turn) ? diff[15:0] : trial[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(OPW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			rem_q <= '0;
		end else if (busy_q) begin
			x_q   <= {x_q[OPW-2:0], 1'b0};
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> hw/rtl/mspt_core.sv
// command sequencer, position state and shared remainder unit
module mspt_core
	import mspt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  logic [7:0] slot_distance,
	input  logic       obuf_empty,
	output push_t      push
);

	state_t         state_q, state_d;
	uop_t           uop_q, uop_d;
	op_t            op_in;
	op_t            op_q;
	logic [15:0]    plate_q, goal_q, off_q;
	logic           active_q;
	logic [OPW-1:0] prod_q;
	logic [15:0]    a_q, b_q, c_q;
	res_t           res0_q, res1_q;
	logic           two_q;
	logic [16:0]    turn;
	logic [OPW-1:0] operand;
	logic           mod_start;
	logic           mod_done;
	logic [15:0]    mod_rem;
	logic           snap;
	logic           accept;

	assign op_in  = op_t'(opcode);
	assign turn   = (cfg.steps_per_turn == 16'd0) ? 17'h10000 : {1'b0, cfg.steps_per_turn};
	assign snap   = mod_rem < cfg.chunk_steps;
	assign accept = (state_q == ST_IDLE) && in_valid;

	mspt_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.x      (operand),
		.turn   (turn),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		uop_d   = uop_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_ISSUE;
					unique case (op_in)
						OP_TICK: begin
							if (active_q) uop_d = U_GOAL;
							else state_d = ST_PUSH;
						end
						OP_CCW: begin
							if (active_q) state_d = ST_PUSH;
							else uop_d = U_CCW;
						end
						OP_CW: begin
							if (active_q) state_d = ST_PUSH;
							else uop_d = U_SLOT;
						end
						OP_HOME: uop_d = U_OFF;
					endcase
				end
			end
			ST_ISSUE: state_d = ST_RUN;
			ST_RUN: begin
				if (mod_done) begin
					state_d = ST_ISSUE;
					case (uop_q)
						U_GOAL:  uop_d = (op_q == OP_TICK) ? U_PLATE : U_NEWG;
						U_PLATE: begin
							if (op_q == OP_TICK) uop_d = U_DIST;
							else if (op_q == OP_CW) uop_d = U_NEWP;
							else uop_d = U_FWD;
						end
						U_DIST: begin
							if (snap) state_d = ST_PUSH;
							else uop_d = U_ADV;
						end
						U_SLOT:  uop_d = U_PLATE;
						U_NEWP:  uop_d = U_GOAL;
						U_NEWG:  uop_d = U_NEWO;
						U_OFF:   uop_d = U_BACK;
						U_BACK:  uop_d = U_PLATE;
						default: state_d = ST_PUSH;
					endcase
				end
			end
			ST_PUSH: begin
				if (obuf_empty) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready   = state_q == ST_IDLE;
		mod_start  = state_q == ST_ISSUE;
		push.valid = (state_q == ST_PUSH) && obuf_empty;
		push.two   = two_q;
		push.r0    = res0_q;
		push.r1    = res1_q;
		case (uop_q)
			U_GOAL:  operand = {8'd0, goal_q};
			U_PLATE: operand = {8'd0, plate_q};
			U_DIST:  operand = {8'd0, a_q} + {7'd0, turn} - {8'd0, b_q};
			U_ADV:   operand = {8'd0, plate_q} + {8'd0, cfg.chunk_steps};
			U_CCW:   operand = {8'd0, goal_q} + prod_q;
			U_SLOT:  operand = {8'd0, cfg.slot_steps};
			U_NEWP:  operand = {8'd0, b_q} + {7'd0, turn} - {8'd0, c_q};
			U_NEWG:  operand = {8'd0, a_q} + {7'd0, turn} - {8'd0, c_q};
			U_NEWO:  operand = {8'd0, off_q} + {8'd0, c_q};
			U_OFF:   operand = {8'd0, off_q};
			U_BACK:  operand = {7'd0, turn} - {8'd0, a_q};
			U_FWD:   operand = {7'd0, turn} - {8'd0, b_q};
			default: operand = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			uop_q    <= U_GOAL;
			plate_q  <= '0;
			goal_q   <= '0;
			off_q    <= '0;
			active_q <= 1'b0;
		end else begin
			state_q <= state_d;
			uop_q   <= uop_d;
			if ((state_q == ST_RUN) && mod_done) begin
				case (uop_q)
					U_DIST: begin
						if (snap) begin
							plate_q  <= a_q;
							active_q <= 1'b0;
						end
					end
					U_ADV: plate_q <= mod_rem;
					U_CCW: begin
						goal_q   <= mod_rem;
						active_q <= 1'b1;
					end
					U_NEWP: plate_q <= mod_rem;
					U_NEWG: goal_q  <= mod_rem;
					U_NEWO: off_q   <= mod_rem;
					U_FWD: begin
						plate_q  <= '0;
						goal_q   <= '0;
						off_q    <= '0;
						active_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_in;
			prod_q <= {16'd0, slot_distance} * {8'd0, cfg.slot_steps};
			two_q  <= 1'b0;
			// quick result for idle tick and busy rotate
			res0_q <= '{last: 1'b1, arrived: !active_q && (op_in == OP_TICK),
				ready_res: !active_q, release_after: 1'b0, step_forward: 1'b0,
				step_count: 16'd0};
		end else if ((state_q == ST_RUN) && mod_done) begin
			case (uop_q)
				U_GOAL:  a_q <= mod_rem;
				U_PLATE: b_q <= mod_rem;
				U_DIST: begin
					c_q <= mod_rem;
					if (snap) begin
						res0_q <= '{last: 1'b1, arrived: 1'b1, ready_res: 1'b1,
							release_after: 1'b1, step_forward: 1'b0, step_count: mod_rem};
					end
				end
				U_ADV: begin
					res0_q <= '{last: 1'b1, arrived: 1'b0, ready_res: 1'b0,
						release_after: 1'b0, step_forward: 1'b0,
						step_count: cfg.chunk_steps};
				end
				U_CCW: begin
					res0_q <= '{last: 1'b1, arrived: 1'b0, ready_res: 1'b0,
						release_after: 1'b0, step_forward: 1'b0, step_count: 16'd0};
				end
				U_SLOT: c_q <= mod_rem;
				U_NEWO: begin
					res0_q <= '{last: 1'b1, arrived: 1'b0, ready_res: 1'b1,
						release_after: 1'b1, step_forward: 1'b1,
						step_count: cfg.slot_steps + {8'd0, cfg.cw_overshoot}};
				end
				U_OFF:  a_q <= mod_rem;
				U_BACK: a_q <= mod_rem;
				U_FWD: begin
					b_q    <= mod_rem;
					two_q  <= 1'b1;
					res0_q <= '{last: 1'b0, arrived: 1'b0, ready_res: 1'b1,
						release_after: 1'b0, step_forward: 1'b0, step_count: a_q};
					res1_q <= '{last: 1'b1, arrived: 1'b0, ready_res: 1'b1,
						release_after: 1'b1, step_forward: 1'b1, step_count: mod_rem};
				end
				default: ;
			endcase
		end
	end

endmodule

>>> hw/rtl/mspt_obuf.sv
// two entry result buffer in front of the output stream
module mspt_obuf
	import mspt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  push_t       push,
	output logic        empty,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,
	output logic        m_axis_tlast
);

	logic [1:0] cnt_q;
	res_t       e0_q, e1_q;
	logic       pop;

	assign pop           = m_axis_tvalid && m_axis_tready;
	assign empty         = cnt_q == 2'd0;
	assign m_axis_tvalid = !empty;
	assign m_axis_tdata  = {4'd0, e0_q.arrived, e0_q.ready_res, e0_q.release_after,
		e0_q.step_forward, e0_q.step_count};
	assign m_axis_tlast  = e0_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push.valid) begin
			cnt_q <= push.two ? 2'd2 : 2'd1;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			e0_q <= push.r0;
			e1_q <= push.r1;
		end else if (pop) begin
			e0_q <= e1_q;
		end
	end

endmodule

>>> hw/rtl/modular_stepper_position_tracker_top.sv
// idle tick or busy rotate go straight to the output buffer; a ccw move, a tick,
// home and a cw move run their modulo steps one after another
// each modulo step runs in the shared bit serial remainder unit
// one command at a time; the next is taken while results wait in the output buffer
// reset: registers 2000/250/10/10, position, goal, offset zero, no move active
`include "assert_macros.svh"
module modular_stepper_position_tracker_top
	import mspt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // slot_distance
	input  logic [1:0]  s_axis_tuser,   // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // step_count, step_forward, release_after,
	                                    // ready_res, arrived
	output logic        m_axis_tlast    // last
);

	cfg_t  cfg_q;
	push_t push;
	logic  obuf_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{steps_per_turn: RST_STEPS_PER_TURN, slot_steps: RST_SLOT_STEPS,
				chunk_steps: RST_CHUNK_STEPS, cw_overshoot: RST_CW_OVERSHOOT};
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STEPS_PER_TURN: cfg_q.steps_per_turn <= cfg_data;
				CFG_SLOT_STEPS:     cfg_q.slot_steps     <= cfg_data;
				CFG_CHUNK_STEPS:    cfg_q.chunk_steps    <= cfg_data;
				CFG_CW_OVERSHOOT:   cfg_q.cw_overshoot   <= cfg_data[7:0];
			endcase
		end
	end

	mspt_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.opcode        (s_axis_tuser),
		.slot_distance (s_axis_tdata),
		.obuf_empty    (obuf_empty),
		.push          (push)
	);

	mspt_obuf u_obuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.empty         (obuf_empty),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	`MSPT_ASSERT_IMP(a_push_into_empty, clk, arst_n, push.valid, obuf_empty)
	`MSPT_ASSERT_NXT(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`MSPT_ASSERT_NXT(a_push_shows_item, clk, arst_n, push.valid, m_axis_tvalid)
	`MSPT_ASSERT_NXT(a_home_first_not_last, clk, arst_n, push.valid && push.two, m_axis_tvalid && !m_axis_tlast)

endmodule

>>> sim/modular_stepper_position_tracker_top_tb.sv
// self-checking testbench of the stepper position tracker with a local position predictor
`timescale 1ns / 1ps
module modular_stepper_position_tracker_top_tb
	import mspt_pkg::*;
();

	localparam int QUIET_LIMIT = 5000;
	localparam int LONG_HOLD   = 800;

	typedef struct {
		op_t         op;
		logic [7:0]  slots;
		int unsigned gap;
	} cmd_t;

	typedef struct {
		logic [15:0] count;
		logic        fwd;
		logic        rel;
		logic        rdy;
		logic        arr;
		logic        fin;
	} move_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_STEPS_PER_TURN;
	logic [15:0] cfg_data = 16'd0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;   // slot_distance
	logic [1:0]  s_axis_tuser = OP_TICK; // opcode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;          // step_count, step_forward, release_after,
	                                    // ready_res, arrived
	logic        m_axis_tlast;          // last

	modular_stepper_position_tracker_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// predictor state and register copy
	logic [15:0] turn_reg  = RST_STEPS_PER_TURN;
	logic [15:0] slot_reg  = RST_SLOT_STEPS;
	logic [15:0] chunk_reg = RST_CHUNK_STEPS;
	logic [7:0]  over_reg  = RST_CW_OVERSHOOT;
	int unsigned plate_pos = 0;
	int unsigned goal_pos = 0;
	int unsigned bottom_off = 0;
	bit          moving = 1'b0;

	cmd_t  cmd_q[$];
	move_t moves_due[$];
	cmd_t  next_cmd;
	move_t want;
	int    items_queued = 0;
	int    items_taken = 0;
	int    errors = 0;
	int    tx_wait = 0;
	int    rx_wait = 0;
	int    rx_calm = 0;
	int    rx_draw = 0;
	int    hold_asks = 0;
	int    hold_seen = 0;
	int    quiet = 0;
	bit    burst = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic add_move(input logic [15:0] count, input logic fwd, input logic rel,
			input logic arr, input logic fin);
		move_t m;
		m.count = count;
		m.fwd   = fwd;
		m.rel   = rel;
		m.rdy   = !moving;
		m.arr   = arr;
		m.fin   = fin;
		moves_due.push_back(m);
	endtask

	task automatic track_command(input op_t op, input logic [7:0] slots);
		int unsigned m;
		int unsigned d;
		int unsigned s;
		int unsigned back;
		m = (turn_reg == 16'd0) ? 32'd65536 : 32'(turn_reg);
		case (op)
			OP_TICK: begin
				if (!moving) begin
					add_move(16'd0, 1'b0, 1'b0, 1'b1, 1'b1);
				end else begin
					d = (goal_pos % m + m - plate_pos % m) % m;
					if (d < 32'(chunk_reg)) begin
						plate_pos = goal_pos % m;
						moving = 1'b0;
						add_move(d[15:0], 1'b0, 1'b1, 1'b1, 1'b1);
					end else begin
						plate_pos = (plate_pos + 32'(chunk_reg)) % m;
						add_move(chunk_reg, 1'b0, 1'b0, 1'b0, 1'b1);
					end
				end
			end
			OP_CCW: begin
				if (!moving) begin
					goal_pos = (goal_pos + 32'(slots) * 32'(slot_reg)) % m;
					moving = 1'b1;
				end
				add_move(16'd0, 1'b0, 1'b0, 1'b0, 1'b1);
			end
			OP_CW: begin
				if (moving) begin
					add_move(16'd0, 1'b0, 1'b0, 1'b0, 1'b1);
				end else begin
					s = 32'(slot_reg) % m;
					plate_pos = (plate_pos % m + m - s) % m;
					goal_pos = (goal_pos % m + m - s) % m;
					bottom_off = (bottom_off + s) % m;
					add_move(16'(slot_reg + 16'(over_reg)), 1'b1, 1'b1, 1'b0, 1'b1);
				end
			end
			default: begin
				back = (m - bottom_off % m) % m;
				d = (m - plate_pos % m) % m;
				plate_pos = 0;
				goal_pos = 0;
				bottom_off = 0;
				moving = 1'b0;
				add_move(back[15:0], 1'b0, 1'b0, 1'b0, 1'b0);
				add_move(d[15:0], 1'b1, 1'b1, 1'b0, 1'b1);
			end
		endcase
	endtask

	task automatic send(input op_t op, input logic [7:0] slots);
		cmd_t c;
		c.op    = op;
		c.slots = slots;
		c.gap   = burst ? 0 : $urandom_range(0, 14);
		track_command(op, slots);
		cmd_q.push_back(c);
		items_queued++;
	endtask

	task automatic drain();
		while (items_taken != items_queued || moves_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_regs(input logic [15:0] turn, input logic [15:0] slot,
			input logic [15:0] chunk, input logic [7:0] over);
		drain();
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_STEPS_PER_TURN;
		cfg_data <= turn;
		@(posedge clk);
		cfg_index <= CFG_SLOT_STEPS;
		cfg_data <= slot;
		@(posedge clk);
		cfg_index <= CFG_CHUNK_STEPS;
		cfg_data <= chunk;
		@(posedge clk);
		cfg_index <= CFG_CW_OVERSHOOT;
		cfg_data <= {8'd0, over};
		@(posedge clk);
		cfg_we <= 1'b0;
		turn_reg = turn;
		slot_reg = slot;
		chunk_reg = chunk;
		over_reg = over;
	endtask

	function automatic logic [7:0] pick_dist();
		return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
			8'($urandom_range(0, 8));
	endfunction

	// mostly ccw moves run to arrival, with busy rotates and stray commands mixed in
	task automatic run_phase(input int budget);
		int start;
		int ticks;
		start = items_queued;
		@(negedge clk);
		while (items_queued - start < budget) begin
			burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 7) begin
				repeat ($urandom_range(0, 2)) send(OP_CW, 8'($urandom));
				send(OP_CCW, pick_dist());
				ticks = 0;
				while (moving && ticks < 60) begin
					if ($urandom_range(0, 7) == 0) begin
						send($urandom_range(0, 1) ? OP_CCW : OP_CW, 8'($urandom));
					end else begin
						send(OP_TICK, 8'($urandom));
						ticks++;
					end
				end
				if (moving || $urandom_range(0, 3) == 0)
					send(OP_HOME, 8'($urandom));
			end else begin
				repeat ($urandom_range(1, 4)) send(op_t'($urandom_range(0, 3)), 8'($urandom));
			end
		end
		drain();
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	task automatic check_field(input string name, input int got, input int exp_val);
		if (got != exp_val)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, exp_val));
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			tx_wait <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				items_taken <= items_taken + 1;
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_wait > 0) begin
					tx_wait <= tx_wait - 1;
					s_axis_tvalid <= 1'b0;
				end else if (cmd_q.size() > 0) begin
					next_cmd = cmd_q.pop_front();
					s_axis_tdata <= next_cmd.slots;
					s_axis_tuser <= next_cmd.op;
					s_axis_tvalid <= 1'b1;
					tx_wait <= next_cmd.gap;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (moves_due.size() == 0) begin
					report_mismatch($sformatf("unexpected item %h last %b", m_axis_tdata,
						m_axis_tlast));
				end else begin
					want = moves_due.pop_front();
					check_field("step_count", m_axis_tdata[15:0], want.count);
					check_field("step_forward", m_axis_tdata[16], want.fwd);
					check_field("release_after", m_axis_tdata[17], want.rel);
					check_field("ready_res", m_axis_tdata[18], want.rdy);
					check_field("arrived", m_axis_tdata[19], want.arr);
					check_field("last", m_axis_tlast, want.fin);
				end
			end
			if (hold_seen != hold_asks) begin
				hold_seen <= hold_asks;
				rx_wait <= LONG_HOLD;
				m_axis_tready <= 1'b0;
			end else if (m_axis_tvalid && m_axis_tready) begin
				if (rx_calm > 0) begin
					rx_calm <= rx_calm - 1;
					rx_draw = 0;
				end else if ($urandom_range(0, 49) == 0) begin
					rx_calm <= 40;
					rx_draw = 0;
				end else begin
					rx_draw = $urandom_range(0, 14);
				end
				rx_wait <= rx_draw;
				m_axis_tready <= (rx_draw == 0);
			end else if (rx_wait > 0) begin
				rx_wait <= rx_wait - 1;
				m_axis_tready <= (rx_wait == 1);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet == QUIET_LIMIT) begin
				$display("modular_stepper_position_tracker_top_tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset register values
		send(OP_TICK, 8'd0);
		send(OP_CCW, 8'd0);
		send(OP_TICK, 8'hff);
		send(OP_CCW, 8'd255);
		send(OP_CCW, 8'd7);
		send(OP_CW, 8'd0);
		send(OP_TICK, 8'h55);
		send(OP_TICK, 8'haa);
		send(OP_HOME, 8'd0);
		send(OP_CW, 8'hff);
		send(OP_CW, 8'd1);
		send(OP_CCW, 8'd1);
		send(OP_TICK, 8'd0);
		send(OP_TICK, 8'd0);
		send(OP_TICK, 8'd0);
		send(OP_HOME, 8'd255);
		send(OP_TICK, 8'd3);
		drain();

		// receiver holds off while the sender keeps offering items back to back
		hold_asks = hold_asks + 1;
		burst = 1'b1;
		repeat (40) send(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 3)));
		drain();

		run_phase(150);
		set_regs(16'd2000, 16'd250, 16'd97, 8'd10);
		run_phase(150);
		set_regs(16'd0, 16'd65535, 16'd4099, 8'd255);
		run_phase(150);
		set_regs(16'd65535, 16'd300, 16'd3001, 8'd255);
		run_phase(150);
		set_regs(16'd150, 16'd40, 16'd7, 8'd3);
		run_phase(150);
		set_regs(16'd1, 16'd0, 16'd65535, 8'd0);
		run_phase(120);
		set_regs(16'd2000, 16'd2500, 16'd150, 8'd5);
		run_phase(150);
		set_regs(16'd97, 16'd13, 16'd0, 8'd1);
		run_phase(120);
		set_regs(16'd3600, 16'd200, 16'd17, 8'd0);
		run_phase(150);

		drain();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("modular_stepper_position_tracker_top_tb: done, clean");
		else
			$display("modular_stepper_position_tracker_top_tb: done, errors");
		$finish;
	end

endmodule
